FILE: rtl/core/bpcr_pkg.sv
`timescale 1ns / 1ps

package bpcr_pkg;

    localparam int DIR_BITS  = 24;
    localparam int DIFF_W    = 33;
    localparam int L1_W      = DIFF_W + 2;
    localparam int SHIFT_W   = $clog2(DIFF_W - DIR_BITS + 1);
    localparam int PROD_W    = 57;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SABS_W    = SUM_W - 1;
    localparam int USQ_W     = 2 * DIR_BITS;
    localparam int Q_W       = USQ_W + 1;
    localparam int CFG_W     = 31;
    localparam int P2_W      = 2 * CFG_W;
    localparam int ROOT_W    = P2_W / 2;
    localparam int VQ_W      = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALL_RADIUS    = 2'd0,
        CFG_COLLISION_PUSH = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] a_pos_x;
        logic signed [31:0] a_pos_y;
        logic signed [31:0] a_pos_z;
        logic signed [31:0] a_vel_x;
        logic signed [31:0] a_vel_y;
        logic signed [31:0] a_vel_z;
        logic signed [31:0] b_pos_x;
        logic signed [31:0] b_pos_y;
        logic signed [31:0] b_pos_z;
        logic signed [31:0] b_vel_x;
        logic signed [31:0] b_vel_y;
        logic signed [31:0] b_vel_z;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] a_delta_vx;
        logic signed [31:0] a_delta_vy;
        logic signed [31:0] a_delta_vz;
        logic signed [31:0] b_delta_vx;
        logic signed [31:0] b_delta_vy;
        logic signed [31:0] b_delta_vz;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic neg, input logic [31:0] mag);
        logic signed [31:0] res;
        if (neg) begin
            res = mag[31] ? 32'sh8000_0000 : -mag;
        end else begin
            res = mag[31] ? 32'sh7fff_ffff : mag;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/bpcr_muldiv.sv
`timescale 1ns / 1ps

module bpcr_muldiv import bpcr_pkg::*; #(
    parameter int ABITS = 57,
    parameter int QBITS = 32,
    parameter int QW    = 49
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [ABITS-1:0] a,
    input  logic [QW-1:0]    b,
    input  logic [QW-1:0]    q,
    output logic [QBITS-1:0] quo
);

    localparam int RW = QW + 2;
    localparam int AW = QBITS + 2;

    logic [ABITS-1:0] a_reg   [ABITS-1];
    logic [QW-1:0]    b_reg   [ABITS-1];
    logic [QW-1:0]    q_reg   [ABITS-1];
    logic [QW-1:0]    r_reg   [ABITS];
    logic [QBITS-1:0] acc_reg [ABITS];

    logic [ABITS-1:0] a_in    [ABITS];
    logic [QW-1:0]    b_in    [ABITS];
    logic [QW-1:0]    q_in    [ABITS];
    logic [QW-1:0]    r_in    [ABITS];
    logic [QBITS-1:0] acc_in  [ABITS];
    logic [QW-1:0]    r_next  [ABITS];
    logic [QBITS-1:0] acc_next[ABITS];

    always_comb begin
        logic [RW-1:0] sum;
        logic [RW-1:0] q1;
        logic [RW-1:0] q2;
        logic [RW-1:0] rem;
        logic [1:0]    dig;
        logic [AW-1:0] accw;
        for (int s = 0; s < ABITS; s++) begin
            if (s == 0) begin
                a_in[s]   = a;
                b_in[s]   = b;
                q_in[s]   = q;
                r_in[s]   = '0;
                acc_in[s] = '0;
            end else begin
                a_in[s]   = a_reg[s-1];
                b_in[s]   = b_reg[s-1];
                q_in[s]   = q_reg[s-1];
                r_in[s]   = r_reg[s-1];
                acc_in[s] = acc_reg[s-1];
            end
            sum = RW'({r_in[s], 1'b0}) + (a_in[s][ABITS-1] ? RW'(b_in[s]) : '0);
            q1  = RW'(q_in[s]);
            q2  = RW'({q_in[s], 1'b0});
            if (sum >= q2) begin
                dig = 2'd2;
                rem = sum - q2;
            end else if (sum >= q1) begin
                dig = 2'd1;
                rem = sum - q1;
            end else begin
                dig = 2'd0;
                rem = sum;
            end
            r_next[s] = rem[QW-1:0];
            accw = AW'({acc_in[s], 1'b0}) + AW'(dig);
            acc_next[s] = (accw[AW-1:QBITS] != '0) ? '1 : accw[QBITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < ABITS; s++) begin
                r_reg[s]   <= r_next[s];
                acc_reg[s] <= acc_next[s];
            end
            for (int s = 0; s < ABITS - 1; s++) begin
                a_reg[s] <= a_in[s] << 1;
                b_reg[s] <= b_in[s];
                q_reg[s] <= q_in[s];
            end
        end
    end

    assign quo = acc_reg[ABITS-1];

endmodule

FILE: rtl/core/bpcr_isqrt.sv
`timescale 1ns / 1ps

module bpcr_isqrt import bpcr_pkg::*; #(
    parameter int VW = 62
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [VW-1:0]   v,
    output logic [VW/2-1:0] root
);

    localparam int RTW = VW / 2;
    localparam int SW  = RTW + 3;

    logic [VW-1:0]  v_reg    [RTW-1];
    logic [RTW:0]   rem_reg  [RTW];
    logic [RTW-1:0] root_reg [RTW];

    logic [VW-1:0]  v_in     [RTW];
    logic [RTW:0]   rem_in   [RTW];
    logic [RTW-1:0] root_in  [RTW];
    logic [RTW:0]   rem_next [RTW];
    logic [RTW-1:0] root_next[RTW];

    always_comb begin
        logic [SW-1:0] cur;
        logic [SW-1:0] trial;
        for (int s = 0; s < RTW; s++) begin
            if (s == 0) begin
                v_in[s]    = v;
                rem_in[s]  = '0;
                root_in[s] = '0;
            end else begin
                v_in[s]    = v_reg[s-1];
                rem_in[s]  = rem_reg[s-1];
                root_in[s] = root_reg[s-1];
            end
            cur   = SW'({rem_in[s], v_in[s][VW-1:VW-2]});
            trial = SW'({root_in[s], 2'b01});
            if (cur >= trial) begin
                rem_next[s]  = (RTW+1)'(cur - trial);
                root_next[s] = {root_in[s][RTW-2:0], 1'b1};
            end else begin
                rem_next[s]  = cur[RTW:0];
                root_next[s] = {root_in[s][RTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < RTW; s++) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
            for (int s = 0; s < RTW - 1; s++) begin
                v_reg[s] <= v_in[s] << 2;
            end
        end
    end

    assign root = root_reg[RTW-1];

endmodule

FILE: rtl/core/ball_pair_collision_response.sv
`timescale 1ns / 1ps

// Collision response for a pair of equal balls: one pair is taken every clock cycle and its
// result passes through 7 front-end stages for differences, direction scaling and dot products,
// 62 stages of bit-serial long division for the push, 31 stages of integer square root, and the
// output register; the velocity deltas come from 57-stage dividers that run alongside and are
// delayed to match. The whole pipeline advances only while the output register is empty or being
// taken, so back-pressure holds every stage in place. The user must write radius and push length
// through cfg_wr_en/cfg_index/cfg_wdata only while no pair is in flight; the block does not enforce it.

module ball_pair_collision_response import bpcr_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int FRONT_DEPTH = 7;
    localparam int VEL_STEPS   = SABS_W;
    localparam int SIDE_DEPTH  = P2_W + ROOT_W;
    localparam int VEL_DELAY   = SIDE_DEPTH - VEL_STEPS;
    localparam int VLD_DEPTH   = FRONT_DEPTH + SIDE_DEPTH;

    typedef struct packed {
        logic               hit;
        logic               zero;
        logic [3:0]         vneg;
        logic               pneg_x;
        logic               pneg_y;
        logic signed [31:0] a_dvz;
        logic signed [31:0] b_dvz;
    } side_t;

    logic [CFG_W-1:0] radius_reg;
    logic [CFG_W-1:0] push_reg;

    logic                 en;
    logic [VLD_DEPTH-1:0] vld_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;
    out_t                 out_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= CFG_W'(1) << FRAC_BITS;
            push_reg   <= CFG_W'(1) << FRAC_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BALL_RADIUS:    radius_reg <= cfg_wdata;
                CFG_COLLISION_PUSH: push_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_DEPTH-2:0], s_valid};
        end
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [31:0]       avx1_reg, avy1_reg, bvx1_reg, bvy1_reg;
    logic signed [31:0]       advz1_reg, bdvz1_reg;
    logic signed [31:0]       advz1_next, bdvz1_next;

    always_comb begin
        advz1_next = sat32(!s_data.a_vel_z[31] && (s_data.a_vel_z != 0),
                           s_data.a_vel_z[31] ? -s_data.a_vel_z : s_data.a_vel_z);
        bdvz1_next = sat32(!s_data.b_vel_z[31] && (s_data.b_vel_z != 0),
                           s_data.b_vel_z[31] ? -s_data.b_vel_z : s_data.b_vel_z);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg   <= DIFF_W'(s_data.b_pos_x) - DIFF_W'(s_data.a_pos_x);
            dy1_reg   <= DIFF_W'(s_data.b_pos_y) - DIFF_W'(s_data.a_pos_y);
            dz1_reg   <= DIFF_W'(s_data.b_pos_z) - DIFF_W'(s_data.a_pos_z);
            avx1_reg  <= s_data.a_vel_x;
            avy1_reg  <= s_data.a_vel_y;
            bvx1_reg  <= s_data.b_vel_x;
            bvy1_reg  <= s_data.b_vel_y;
            advz1_reg <= advz1_next;
            bdvz1_reg <= bdvz1_next;
        end
    end

    // stage 2: magnitudes
    logic [DIFF_W-1:0]  mx2_reg, my2_reg, mz2_reg;
    logic               xneg2_reg, yneg2_reg;
    logic signed [31:0] avx2_reg, avy2_reg, bvx2_reg, bvy2_reg, advz2_reg, bdvz2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx2_reg   <= dx1_reg[DIFF_W-1] ? DIFF_W'(-dx1_reg) : DIFF_W'(dx1_reg);
            my2_reg   <= dy1_reg[DIFF_W-1] ? DIFF_W'(-dy1_reg) : DIFF_W'(dy1_reg);
            mz2_reg   <= dz1_reg[DIFF_W-1] ? DIFF_W'(-dz1_reg) : DIFF_W'(dz1_reg);
            xneg2_reg <= dx1_reg[DIFF_W-1];
            yneg2_reg <= dy1_reg[DIFF_W-1];
            avx2_reg  <= avx1_reg;
            avy2_reg  <= avy1_reg;
            bvx2_reg  <= bvx1_reg;
            bvy2_reg  <= bvy1_reg;
            advz2_reg <= advz1_reg;
            bdvz2_reg <= bdvz1_reg;
        end
    end

    // stage 3: hit test and direction scaling
    logic [L1_W-1:0]           l1_3;
    logic [DIFF_W-1:0]         m3, shx3, shy3;
    logic [SHIFT_W-1:0]        k3;
    logic [DIR_BITS-1:0]       uxm3_next, uym3_next;
    logic                      xneg3_next, yneg3_next;
    logic [DIR_BITS-1:0]       uxm3_reg, uym3_reg;
    logic signed [DIR_BITS:0]  ux3_reg, uy3_reg;
    logic                      xneg3_reg, yneg3_reg, zero3_reg, hit3_reg;
    logic signed [31:0]        avx3_reg, avy3_reg, bvx3_reg, bvy3_reg, advz3_reg, bdvz3_reg;

    always_comb begin
        l1_3 = L1_W'(mx2_reg) + L1_W'(my2_reg) + L1_W'(mz2_reg);
        m3   = (mx2_reg > my2_reg) ? mx2_reg : my2_reg;
        k3   = '0;
        for (int i = 0; i < DIFF_W - DIR_BITS; i++) begin
            if (m3[DIR_BITS+i]) begin
                k3 = SHIFT_W'(i + 1);
            end
        end
        shx3 = mx2_reg >> k3;
        shy3 = my2_reg >> k3;
        if (m3 == '0) begin
            uxm3_next  = DIR_BITS'(1);
            uym3_next  = '0;
            xneg3_next = 1'b0;
            yneg3_next = 1'b0;
        end else begin
            uxm3_next  = shx3[DIR_BITS-1:0];
            uym3_next  = shy3[DIR_BITS-1:0];
            xneg3_next = xneg2_reg;
            yneg3_next = yneg2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit3_reg  <= l1_3 <= L1_W'({radius_reg, 1'b0});
            zero3_reg <= m3 == '0;
            uxm3_reg  <= uxm3_next;
            uym3_reg  <= uym3_next;
            ux3_reg   <= xneg3_next ? -$signed({1'b0, uxm3_next}) : $signed({1'b0, uxm3_next});
            uy3_reg   <= yneg3_next ? -$signed({1'b0, uym3_next}) : $signed({1'b0, uym3_next});
            xneg3_reg <= xneg3_next;
            yneg3_reg <= yneg3_next;
            avx3_reg  <= avx2_reg;
            avy3_reg  <= avy2_reg;
            bvx3_reg  <= bvx2_reg;
            bvy3_reg  <= bvy2_reg;
            advz3_reg <= advz2_reg;
            bdvz3_reg <= bdvz2_reg;
        end
    end

    // stage 4: products
    logic signed [PROD_W-1:0] pax4_reg, pay4_reg, pbx4_reg, pby4_reg;
    logic [USQ_W-1:0]         ux2_4_reg, uy2_4_reg;
    logic [P2_W-1:0]          p2_4_reg;
    logic [DIR_BITS-1:0]      uxm4_reg, uym4_reg;
    logic                     xneg4_reg, yneg4_reg, zero4_reg, hit4_reg;
    logic signed [31:0]       advz4_reg, bdvz4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pax4_reg  <= avx3_reg * ux3_reg;
            pay4_reg  <= avy3_reg * uy3_reg;
            pbx4_reg  <= bvx3_reg * ux3_reg;
            pby4_reg  <= bvy3_reg * uy3_reg;
            ux2_4_reg <= uxm3_reg * uxm3_reg;
            uy2_4_reg <= uym3_reg * uym3_reg;
            p2_4_reg  <= push_reg * push_reg;
            uxm4_reg  <= uxm3_reg;
            uym4_reg  <= uym3_reg;
            xneg4_reg <= xneg3_reg;
            yneg4_reg <= yneg3_reg;
            zero4_reg <= zero3_reg;
            hit4_reg  <= hit3_reg;
            advz4_reg <= advz3_reg;
            bdvz4_reg <= bdvz3_reg;
        end
    end

    // stage 5: dot products and squared length
    logic signed [SUM_W-1:0] da5_reg, db5_reg;
    logic [Q_W-1:0]          q5_reg;
    logic [USQ_W-1:0]        ux2_5_reg, uy2_5_reg;
    logic [P2_W-1:0]         p2_5_reg;
    logic [DIR_BITS-1:0]     uxm5_reg, uym5_reg;
    logic                    xneg5_reg, yneg5_reg, zero5_reg, hit5_reg;
    logic signed [31:0]      advz5_reg, bdvz5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            da5_reg   <= SUM_W'(pax4_reg) + SUM_W'(pay4_reg);
            db5_reg   <= SUM_W'(pbx4_reg) + SUM_W'(pby4_reg);
            q5_reg    <= Q_W'(ux2_4_reg) + Q_W'(uy2_4_reg);
            ux2_5_reg <= ux2_4_reg;
            uy2_5_reg <= uy2_4_reg;
            p2_5_reg  <= p2_4_reg;
            uxm5_reg  <= uxm4_reg;
            uym5_reg  <= uym4_reg;
            xneg5_reg <= xneg4_reg;
            yneg5_reg <= yneg4_reg;
            zero5_reg <= zero4_reg;
            hit5_reg  <= hit4_reg;
            advz5_reg <= advz4_reg;
            bdvz5_reg <= bdvz4_reg;
        end
    end

    // stage 6: exchanged normal speeds
    logic signed [SUM_W-1:0] absda6, absdb6;
    logic signed [SUM_W-1:0] sa6_reg, sb6_reg;
    logic [Q_W-1:0]          q6_reg;
    logic [USQ_W-1:0]        ux2_6_reg, uy2_6_reg;
    logic [P2_W-1:0]         p2_6_reg;
    logic [DIR_BITS-1:0]     uxm6_reg, uym6_reg;
    logic                    xneg6_reg, yneg6_reg, zero6_reg, hit6_reg;
    logic signed [31:0]      advz6_reg, bdvz6_reg;

    always_comb begin
        absda6 = da5_reg[SUM_W-1] ? -da5_reg : da5_reg;
        absdb6 = db5_reg[SUM_W-1] ? -db5_reg : db5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa6_reg   <= da5_reg + absdb6;
            sb6_reg   <= absda6 - db5_reg;
            q6_reg    <= q5_reg;
            ux2_6_reg <= ux2_5_reg;
            uy2_6_reg <= uy2_5_reg;
            p2_6_reg  <= p2_5_reg;
            uxm6_reg  <= uxm5_reg;
            uym6_reg  <= uym5_reg;
            xneg6_reg <= xneg5_reg;
            yneg6_reg <= yneg5_reg;
            zero6_reg <= zero5_reg;
            hit6_reg  <= hit5_reg;
            advz6_reg <= advz5_reg;
            bdvz6_reg <= bdvz5_reg;
        end
    end

    // stage 7: magnitudes for the dividers
    logic [SABS_W-1:0]   absa7_reg, absb7_reg;
    logic                saneg7_reg, sbneg7_reg;
    logic [Q_W-1:0]      q7_reg;
    logic [USQ_W-1:0]    ux2_7_reg, uy2_7_reg;
    logic [P2_W-1:0]     p2_7_reg;
    logic [DIR_BITS-1:0] uxm7_reg, uym7_reg;
    logic                xneg7_reg, yneg7_reg, zero7_reg, hit7_reg;
    logic signed [31:0]  advz7_reg, bdvz7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            absa7_reg  <= sa6_reg[SUM_W-1] ? SABS_W'(-sa6_reg) : SABS_W'(sa6_reg);
            absb7_reg  <= sb6_reg[SUM_W-1] ? SABS_W'(-sb6_reg) : SABS_W'(sb6_reg);
            saneg7_reg <= sa6_reg[SUM_W-1];
            sbneg7_reg <= sb6_reg[SUM_W-1];
            q7_reg     <= q6_reg;
            ux2_7_reg  <= ux2_6_reg;
            uy2_7_reg  <= uy2_6_reg;
            p2_7_reg   <= p2_6_reg;
            uxm7_reg   <= uxm6_reg;
            uym7_reg   <= uym6_reg;
            xneg7_reg  <= xneg6_reg;
            yneg7_reg  <= yneg6_reg;
            zero7_reg  <= zero6_reg;
            hit7_reg   <= hit6_reg;
            advz7_reg  <= advz6_reg;
            bdvz7_reg  <= bdvz6_reg;
        end
    end

    // dividers and square roots
    logic [VQ_W-1:0]   vq_ax, vq_ay, vq_bx, vq_by;
    logic [P2_W-1:0]   pq_x, pq_y;
    logic [ROOT_W-1:0] root_x, root_y;

    bpcr_muldiv #(.ABITS(SABS_W), .QBITS(VQ_W), .QW(Q_W)) u_div_ax (
        .aclk(aclk), .en(en), .a(absa7_reg), .b(Q_W'(uxm7_reg)), .q(q7_reg), .quo(vq_ax)
    );
    bpcr_muldiv #(.ABITS(SABS_W), .QBITS(VQ_W), .QW(Q_W)) u_div_ay (
        .aclk(aclk), .en(en), .a(absa7_reg), .b(Q_W'(uym7_reg)), .q(q7_reg), .quo(vq_ay)
    );
    bpcr_muldiv #(.ABITS(SABS_W), .QBITS(VQ_W), .QW(Q_W)) u_div_bx (
        .aclk(aclk), .en(en), .a(absb7_reg), .b(Q_W'(uxm7_reg)), .q(q7_reg), .quo(vq_bx)
    );
    bpcr_muldiv #(.ABITS(SABS_W), .QBITS(VQ_W), .QW(Q_W)) u_div_by (
        .aclk(aclk), .en(en), .a(absb7_reg), .b(Q_W'(uym7_reg)), .q(q7_reg), .quo(vq_by)
    );
    bpcr_muldiv #(.ABITS(P2_W), .QBITS(P2_W), .QW(Q_W)) u_div_px (
        .aclk(aclk), .en(en), .a(p2_7_reg), .b(Q_W'(ux2_7_reg)), .q(q7_reg), .quo(pq_x)
    );
    bpcr_muldiv #(.ABITS(P2_W), .QBITS(P2_W), .QW(Q_W)) u_div_py (
        .aclk(aclk), .en(en), .a(p2_7_reg), .b(Q_W'(uy2_7_reg)), .q(q7_reg), .quo(pq_y)
    );
    bpcr_isqrt #(.VW(P2_W)) u_sqrt_x (.aclk(aclk), .en(en), .v(pq_x), .root(root_x));
    bpcr_isqrt #(.VW(P2_W)) u_sqrt_y (.aclk(aclk), .en(en), .v(pq_y), .root(root_y));

    // side data travels alongside the dividers
    side_t side7;
    side_t side_reg [SIDE_DEPTH];
    side_t side_vel, side_end;

    always_comb begin
        side7.hit    = hit7_reg;
        side7.zero   = zero7_reg;
        side7.vneg   = {~(xneg7_reg ^ saneg7_reg), ~(yneg7_reg ^ saneg7_reg),
                        xneg7_reg ^ sbneg7_reg, yneg7_reg ^ sbneg7_reg};
        side7.pneg_x = ~xneg7_reg;
        side7.pneg_y = ~yneg7_reg;
        side7.a_dvz  = advz7_reg;
        side7.b_dvz  = bdvz7_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side7;
            for (int j = 1; j < SIDE_DEPTH; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign side_vel = side_reg[VEL_STEPS-1];
    assign side_end = side_reg[SIDE_DEPTH-1];

    // velocity deltas wait for the push path
    logic [3:0][31:0] vel_fmt;
    logic [3:0][31:0] vel_reg [VEL_DELAY];

    always_comb begin
        vel_fmt[3] = sat32(side_vel.vneg[3], vq_ax);
        vel_fmt[2] = sat32(side_vel.vneg[2], vq_ay);
        vel_fmt[1] = sat32(side_vel.vneg[1], vq_bx);
        vel_fmt[0] = sat32(side_vel.vneg[0], vq_by);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vel_reg[0] <= vel_fmt;
            for (int j = 1; j < VEL_DELAY; j++) begin
                vel_reg[j] <= vel_reg[j-1];
            end
        end
    end

    always_comb begin
        out_next.hit        = side_end.hit;
        out_next.a_delta_vx = vel_reg[VEL_DELAY-1][3];
        out_next.a_delta_vy = vel_reg[VEL_DELAY-1][2];
        out_next.a_delta_vz = side_end.a_dvz;
        out_next.b_delta_vx = vel_reg[VEL_DELAY-1][1];
        out_next.b_delta_vy = vel_reg[VEL_DELAY-1][0];
        out_next.b_delta_vz = side_end.b_dvz;
        if (side_end.zero) begin
            out_next.push_x = {1'b0, push_reg};
            out_next.push_y = '0;
        end else begin
            out_next.push_x = sat32(side_end.pneg_x, 32'(root_x));
            out_next.push_y = sat32(side_end.pneg_y, 32'(root_y));
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[VLD_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transaction missing from first stage");

    a_push_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[VLD_DEPTH-1] |-> (root_x <= push_reg) && (root_y <= push_reg))
        else $error("push magnitude exceeds configured length");

    a_coincident_y: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[VLD_DEPTH-1] && side_end.zero) |-> (root_y == '0))
        else $error("coincident centres gave nonzero y push");

endmodule

FILE: tb/ball_pair_collision_response_tb.sv
`timescale 1ns / 1ps

module ball_pair_collision_response_tb;
    import bpcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [CFG_W-1:0]     CFG_MAX       = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0]     ONE_Q16       = 31'd65536;
    localparam int                   LATENCY       = 101;

    typedef struct {
        in_t  stim;
        bit   typed;
        out_t want;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    longint unsigned radius_q16;
    longint unsigned push_len_q16;
    out_t            response_q[$];
    row_t            table_rows[$];
    int              mismatches;
    bit              quiet;

    ball_pair_collision_response u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic logic signed [31:0] clamp32(bit neg, logic [127:0] m);
        if (neg) begin
            return m >= 128'h8000_0000 ? 32'sh8000_0000 : -m[31:0];
        end
        return m > 128'h7fff_ffff ? 32'sh7fff_ffff : m[31:0];
    endfunction

    // u * s / q truncated toward zero, optionally negated
    function automatic logic signed [31:0] along_normal(longint u, longint s,
                                                        longint unsigned q, bit flip);
        logic [127:0] m;
        bit           neg;
        m   = ({64'b0, mag(u)} * {64'b0, mag(s)}) / {64'b0, q};
        neg = ((u < 0) != (s < 0)) != flip;
        return clamp32(neg && m != 0, m);
    endfunction

    // largest t below 2^31 with t*t*q <= (p*um)^2
    function automatic longint unsigned push_component(longint unsigned p,
                                                       longint unsigned um,
                                                       longint unsigned q);
        logic [127:0]    rhs;
        logic [127:0]    c;
        longint unsigned t;
        t   = 0;
        rhs = {64'b0, p * um} * {64'b0, p * um};
        for (int i = 30; i >= 0; i--) begin
            c = {64'b0, t | (64'd1 << i)};
            if (c * c * {64'b0, q} <= rhs) begin
                t = c[63:0];
            end
        end
        return t;
    endfunction

    function automatic out_t collision_response(in_t p);
        longint          dx, dy, dz, ux, uy, da, db, sa, sb;
        longint unsigned mx, my, mm, q, px, py;
        int              k;
        out_t            r;
        dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
        dy = longint'(p.b_pos_y) - longint'(p.a_pos_y);
        dz = longint'(p.b_pos_z) - longint'(p.a_pos_z);
        mx = mag(dx);
        my = mag(dy);
        mm = mx > my ? mx : my;
        r.hit = (mx + my + mag(dz)) <= 2 * radius_q16;
        if (mm == 0) begin
            ux = 1;
            uy = 0;
        end else begin
            k = 0;
            while ((mm >> k) >= (64'd1 << DIR_BITS)) k++;
            ux = mx >> k;
            uy = my >> k;
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
        end
        q  = ux * ux + uy * uy;
        da = longint'(p.a_vel_x) * ux + longint'(p.a_vel_y) * uy;
        db = longint'(p.b_vel_x) * ux + longint'(p.b_vel_y) * uy;
        sa = da + longint'(mag(db));
        sb = longint'(mag(da)) - db;
        r.a_delta_vx = along_normal(ux, sa, q, 1'b1);
        r.a_delta_vy = along_normal(uy, sa, q, 1'b1);
        r.a_delta_vz = clamp32(p.a_vel_z > 0, mag(p.a_vel_z));
        r.b_delta_vx = along_normal(ux, sb, q, 1'b0);
        r.b_delta_vy = along_normal(uy, sb, q, 1'b0);
        r.b_delta_vz = clamp32(p.b_vel_z > 0, mag(p.b_vel_z));
        if (mm == 0) begin
            r.push_x = push_len_q16[31:0];
            r.push_y = '0;
        end else begin
            px = push_component(push_len_q16, mag(ux), q);
            py = push_component(push_len_q16, mag(uy), q);
            r.push_x = clamp32(ux > 0 && px != 0, px);
            r.push_y = clamp32(uy > 0 && py != 0, py);
        end
        return r;
    endfunction

    function automatic in_t pair(longint apx, longint apy, longint apz,
                                 longint avx, longint avy, longint avz,
                                 longint bpx, longint bpy, longint bpz,
                                 longint bvx, longint bvy, longint bvz);
        in_t p;
        p.a_pos_x = apx[31:0]; p.a_pos_y = apy[31:0]; p.a_pos_z = apz[31:0];
        p.a_vel_x = avx[31:0]; p.a_vel_y = avy[31:0]; p.a_vel_z = avz[31:0];
        p.b_pos_x = bpx[31:0]; p.b_pos_y = bpy[31:0]; p.b_pos_z = bpz[31:0];
        p.b_vel_x = bvx[31:0]; p.b_vel_y = bvy[31:0]; p.b_vel_z = bvz[31:0];
        return p;
    endfunction

    function automatic longint rand_s32();
        return longint'(signed'($urandom()));
    endfunction

    function automatic longint near(longint base, longint span);
        return base + longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic in_t random_pair();
        longint base_x, base_y, base_z, span, vmax;
        int     mode;
        in_t    p;
        mode = $urandom_range(9);
        span = 64'd1 << $urandom_range(4, 26);
        vmax = 64'd1 << $urandom_range(8, 31);
        if (mode < 3) begin
            p = pair(rand_s32(), rand_s32(), rand_s32(), rand_s32(), rand_s32(), rand_s32(),
                     rand_s32(), rand_s32(), rand_s32(), rand_s32(), rand_s32(), rand_s32());
        end else begin
            base_x = $urandom_range(0, 1 << 30) - (1 << 29);
            base_y = $urandom_range(0, 1 << 30) - (1 << 29);
            base_z = $urandom_range(0, 1 << 30) - (1 << 29);
            p = pair(base_x, base_y, base_z,
                     near(0, vmax - 1), near(0, vmax - 1), near(0, vmax - 1),
                     mode == 3 ? base_x : near(base_x, span),
                     mode == 3 ? base_y : near(base_y, span),
                     near(base_z, span),
                     near(0, vmax - 1), near(0, vmax - 1), near(0, vmax - 1));
        end
        return p;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BALL_RADIUS) begin
            radius_q16 = value;
        end else if (idx == CFG_COLLISION_PUSH) begin
            push_len_q16 = value;
        end
        @(posedge aclk);
    endtask

    task automatic send_pair(in_t p, bit typed, out_t want);
        while (!quiet && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        response_q.push_back(typed ? want : collision_response(p));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (response_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(int count);
        out_t none;
        none = '0;
        for (int i = 0; i < count; i++) send_pair(random_pair(), 1'b0, none);
        drain();
    endtask

    always @(posedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // result transaction check
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (response_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = response_q.pop_front();
                if (want.hit !== m_data.hit || want.a_delta_vx !== m_data.a_delta_vx
                    || want.a_delta_vy !== m_data.a_delta_vy
                    || want.a_delta_vz !== m_data.a_delta_vz
                    || want.b_delta_vx !== m_data.b_delta_vx
                    || want.b_delta_vy !== m_data.b_delta_vy
                    || want.b_delta_vz !== m_data.b_delta_vz
                    || want.push_x !== m_data.push_x || want.push_y !== m_data.push_y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch hit/avx/avy/avz/bvx/bvy/bvz/px/py");
                        $display("  exp %b %h %h %h %h %h %h %h %h", want.hit,
                                 want.a_delta_vx, want.a_delta_vy, want.a_delta_vz,
                                 want.b_delta_vx, want.b_delta_vy, want.b_delta_vz,
                                 want.push_x, want.push_y);
                        $display("  got %b %h %h %h %h %h %h %h %h", m_data.hit,
                                 m_data.a_delta_vx, m_data.a_delta_vy, m_data.a_delta_vz,
                                 m_data.b_delta_vx, m_data.b_delta_vy, m_data.b_delta_vz,
                                 m_data.push_x, m_data.push_y);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        row_t   r;
        longint mn, mx;
        mn = -64'sd2147483648;
        mx = 64'sd2147483647;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_BALL_RADIUS;
        cfg_wdata    = '0;
        radius_q16   = ONE_Q16;
        push_len_q16 = ONE_Q16;
        mismatches   = 0;
        quiet        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coincident centres at rest: normal (1,0), push along +x
        r.stim = pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want = '0;
        r.want.hit = 1'b1;
        r.want.push_x = 32'sh0001_0000;
        table_rows.push_back(r);
        // z velocity cancel with saturation
        r.stim = pair(0, 0, 0, 0, 0, mn, 0, 0, 0, 0, 0, mx);
        r.want.a_delta_vz = 32'sh7fff_ffff;
        r.want.b_delta_vz = 32'sh8000_0001;
        table_rows.push_back(r);
        r.typed = 1'b0;
        r.stim = pair(5, 7, 0, mn, 3, 0, 5, 7, 9, mn, mx, 1);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, mx, mn, mn, 0, 0, 0, mx, mx, mn);
        table_rows.push_back(r);
        r.stim = pair(mn, mn, mn, mx, mx, mx, mx, mx, mx, mn, mn, mn);
        table_rows.push_back(r);
        r.stim = pair(mx, mx, mx, mn, mn, mn, mn, mn, mn, mx, mx, mx);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 65536, 0, 0, 131072, 0, 0, -65536, 0, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 65536, 0, 0, 131073, 0, 0, -65536, 0, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 0, 65536, 0, 0, -131072, 0, 0, 4096, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 0, 0, 0, 65536, 0, 65536, 0, 0, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 1, 0, 0, 0, 65536, 0, 65536, 0, 0, 0);
        table_rows.push_back(r);
        r.stim = pair(100, 100, 0, 70000, -3000, 5, 40000, 160000, 0, -12, 9000, -5);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 1, 1, 0, 1, 1, 0, -1, -1, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, -1, 0, 0, -1, 0, 0, 1, 0, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, mx, mx, 0, 1, 16777215, 0, mn, mn, 0);
        table_rows.push_back(r);
        r.stim = pair(-7, 3, 0, mn, mn, 0, 16777216, -16777217, 0, mx, mx, 0);
        table_rows.push_back(r);
        r.stim = pair(0, 0, 0, 12345, -54321, 77, 0, 3, 0, -999, 888, -77);
        table_rows.push_back(r);
        r.stim = pair(mn, 0, 0, mx, 0, 0, mx, 0, 0, mx, 0, 0);
        table_rows.push_back(r);

        foreach (table_rows[i]) begin
            send_pair(table_rows[i].stim, table_rows[i].typed, table_rows[i].want);
        end
        drain();

        cfg_write(CFG_IDX_SPARE, CFG_MAX);
        run_random(40);
        cfg_write(CFG_BALL_RADIUS, '0);
        cfg_write(CFG_COLLISION_PUSH, '0);
        run_random(80);
        cfg_write(CFG_BALL_RADIUS, CFG_MAX);
        cfg_write(CFG_COLLISION_PUSH, CFG_MAX);
        quiet = 1'b1;
        run_random(110);
        quiet = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(CFG_BALL_RADIUS, $urandom() >> (1 + $urandom_range(0, 20)));
            cfg_write(CFG_COLLISION_PUSH, $urandom() >> 1);
            run_random(80);
        end
        cfg_write(CFG_BALL_RADIUS, ONE_Q16);
        cfg_write(CFG_COLLISION_PUSH, ONE_Q16);
        run_random(80);

        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && response_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bpcr_pkg.sv
rtl/core/bpcr_muldiv.sv
rtl/core/bpcr_isqrt.sv
rtl/core/ball_pair_collision_response.sv
tb/ball_pair_collision_response_tb.sv
